@@ rtl/ra_mutex_pkg.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_pkg
// Shared types and codes for the mutual exclusion node: action and message
// codes, node modes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ra_mutex_pkg;

   // node table size and field widths
   localparam int MAX_NODES = 16;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int TS_W      = 32;
   localparam int RES_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = CNT_W;

   // input actions
   localparam logic [1:0] ACT_RECV_REQ = 2'd0;
   localparam logic [1:0] ACT_RECV_ACK = 2'd1;
   localparam logic [1:0] ACT_REQUEST  = 2'd2;
   localparam logic [1:0] ACT_RELEASE  = 2'd3;

   // node modes
   localparam logic [1:0] MODE_REST    = 2'd0;
   localparam logic [1:0] MODE_WAIT    = 2'd1;
   localparam logic [1:0] MODE_SECTION = 2'd2;

   // message kinds
   localparam logic KIND_REQ = 1'b0;
   localparam logic KIND_ACK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MY_NODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b1;

   // one result item
   typedef struct packed {
      logic             send_valid;
      logic             send_kind;
      logic [NODE_W-1:0] dest_node;
      logic [RES_W-1:0] send_resource;
      logic [TS_W-1:0]  send_timestamp;
      logic [1:0]       node_state;
      logic             last;
   } rsp_item_type;

   // result push from the controller to the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

   // stamp memory command
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [NODE_W-1:0] addr;
      logic [TS_W-1:0]   wdata;
   } ram_cmd_type;

endpackage

@@ rtl/ra_mutex_req_if.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_req_if
// Input channel: one action with its message fields per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ra_mutex_req_if
   import ra_mutex_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [1:0]       action;
   logic [TS_W-1:0]  msg_timestamp;
   logic [NODE_W-1:0] sender;
   logic [RES_W-1:0] resource;

   modport source (output valid, action, msg_timestamp, sender, resource, input ready);
   modport sink   (input valid, action, msg_timestamp, sender, resource, output ready);
endinterface

@@ rtl/ra_mutex_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_rsp_if
// Result channel: one outgoing message slot per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ra_mutex_rsp_if
   import ra_mutex_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             send_valid;
   logic             send_kind;
   logic [NODE_W-1:0] dest_node;
   logic [RES_W-1:0] send_resource;
   logic [TS_W-1:0]  send_timestamp;
   logic [1:0]       node_state;
   logic             last;

   modport source (output valid, send_valid, send_kind, dest_node, send_resource,
                   send_timestamp, node_state, last, input ready);
   modport sink   (input valid, send_valid, send_kind, dest_node, send_resource,
                   send_timestamp, node_state, last, output ready);
endinterface

@@ rtl/ra_mutex_csr_if.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ra_mutex_csr_if
   import ra_mutex_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/ra_mutex_stamp_ram.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_stamp_ram
// Single-port stamp memory, one entry per node, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ra_mutex_stamp_ram
   import ra_mutex_pkg::*;
(
   input  logic            clock,
   input  ram_cmd_type     cmd,
   output logic [TS_W-1:0] rdata
);

   logic [TS_W-1:0] mem [MAX_NODES];
   logic [TS_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/ra_mutex_out_reg.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_out_reg
// Output register of the result channel; takes a new result when empty or in
// the cycle the held one transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ra_mutex_out_reg
   import ra_mutex_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rsp_push_type   push,
   output logic           free,
   ra_mutex_rsp_if.source rsp_ch
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp_ch.ready;

   // hold until transfer, reload on push
   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         item_ff <= push.item;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.send_valid     = item_ff.send_valid;
   assign rsp_ch.send_kind      = item_ff.send_kind;
   assign rsp_ch.dest_node      = item_ff.dest_node;
   assign rsp_ch.send_resource  = item_ff.send_resource;
   assign rsp_ch.send_timestamp = item_ff.send_timestamp;
   assign rsp_ch.node_state     = item_ff.node_state;
   assign rsp_ch.last           = item_ff.last;

endmodule

@@ rtl/ra_mutex_ctrl.sv @@
// ----------------------------------------------------------------------------
// ra_mutex_ctrl
// Protocol sequencer: Lamport clock, node mode, ack and deferral marks, and
// the walk over peers that sends REQ or deferred ACK messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ra_mutex_ctrl
   import ra_mutex_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   ra_mutex_req_if.sink    req_ch,
   ra_mutex_csr_if.sink    csr_ch,
   output ram_cmd_type     ram_cmd,
   input  logic [TS_W-1:0] ram_rdata,
   input  logic            out_free,
   output rsp_push_type    push
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_JUDGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_SCAN  = 2'd3;

   logic [1:0]          state_ff,     state_in;
   logic [TS_W-1:0]     clk_ff,       clk_in;
   logic [1:0]          mode_ff,      mode_in;
   logic [RES_W-1:0]    held_ff,      held_in;
   logic [CNT_W-1:0]    ack_cnt_ff,   ack_cnt_in;
   logic [MAX_NODES-1:0] ack_seen_ff, ack_seen_in;
   logic [MAX_NODES-1:0] deferred_ff, deferred_in;
   logic [MAX_NODES-1:0] stamp_vld_ff, stamp_vld_in;
   logic [MAX_NODES-1:0] mask_ff,     mask_in;
   logic                kind_ff,      kind_in;
   logic [RES_W-1:0]    res_ff,       res_in;
   logic [TS_W-1:0]     ts_ff,        ts_in;
   logic [NODE_W-1:0]   snd_ff,       snd_in;
   logic [NODE_W-1:0]   my_node_ff,   my_node_in;
   logic [CNT_W-1:0]    node_count_ff, node_count_in;

   logic [CNT_W-1:0]     eff_n;
   logic [CNT_W-1:0]     need;
   logic [MAX_NODES-1:0] peer_mask;
   logic [TS_W-1:0]      clk_seen;
   logic [TS_W-1:0]      clk_inc;
   logic [MAX_NODES-1:0] low_bit;
   logic [NODE_W-1:0]    low_idx;
   logic                 scan_last;
   logic [TS_W-1:0]      mine;
   logic                 answer;
   logic                 ack_new;
   logic [CNT_W-1:0]     ack_cnt_next;
   logic                 accept;

   // effective node count and peer set
   always_comb begin
      if (node_count_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         eff_n = CNT_W'(MAX_NODES);
      end else begin
         eff_n = node_count_ff;
      end
      need = eff_n - CNT_W'(1);
      for (int i = 0; i < MAX_NODES; i++) begin
         if (NODE_W'(i) == my_node_ff) begin
            peer_mask[i] = 1'b0;
         end else if (CNT_W'(my_node_ff) < eff_n) begin
            peer_mask[i] = CNT_W'(i) < eff_n;
         end else begin
            peer_mask[i] = CNT_W'(i) < need;
         end
      end
   end

   // clock update for received messages and plain increment
   assign clk_seen = ((clk_ff > req_ch.msg_timestamp) ? clk_ff : req_ch.msg_timestamp)
                     + TS_W'(1);
   assign clk_inc  = clk_ff + TS_W'(1);

   // lowest pending node of the walk
   always_comb begin
      low_bit = mask_ff & (~mask_ff + MAX_NODES'(1));
      low_idx = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (low_bit[i]) begin
            low_idx = NODE_W'(i);
         end
      end
      scan_last = (mask_ff & ~low_bit) == '0;
   end

   // priority of a competing request; an entry not written since the
   // last request reads as zero
   always_comb begin
      mine = stamp_vld_ff[snd_ff] ? ram_rdata : '0;
      if (!peer_mask[snd_ff] || mode_ff == MODE_REST) begin
         answer = 1'b1;
      end else if (held_ff != res_ff) begin
         answer = 1'b1;
      end else if (mode_ff == MODE_WAIT) begin
         answer = (ts_ff < mine) || (ts_ff == mine && snd_ff < my_node_ff);
      end else begin
         answer = 1'b0;
      end
   end

   // ack counting
   assign ack_new      = peer_mask[req_ch.sender] && !ack_seen_ff[req_ch.sender];
   assign ack_cnt_next = ack_cnt_ff + CNT_W'(ack_new);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clk_in        = clk_ff;
      mode_in       = mode_ff;
      held_in       = held_ff;
      ack_cnt_in    = ack_cnt_ff;
      ack_seen_in   = ack_seen_ff;
      deferred_in   = deferred_ff;
      stamp_vld_in  = stamp_vld_ff;
      mask_in       = mask_ff;
      kind_in       = kind_ff;
      res_in        = res_ff;
      ts_in         = ts_ff;
      snd_in        = snd_ff;
      my_node_in    = my_node_ff;
      node_count_in = node_count_ff;
      ram_cmd       = '0;
      push          = '0;

      // configuration transfer
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MY_NODE:    my_node_in    = csr_ch.wdata[NODE_W-1:0];
            CSR_NODE_COUNT: node_count_in = csr_ch.wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ts_in  = req_ch.msg_timestamp;
               snd_in = req_ch.sender;
               res_in = req_ch.resource;
               unique case (req_ch.action)
                  ACT_RECV_REQ: begin
                     clk_in        = clk_seen;
                     ram_cmd.rd_en = 1'b1;
                     ram_cmd.addr  = req_ch.sender;
                     state_in      = ST_JUDGE;
                  end
                  ACT_RECV_ACK: begin
                     clk_in     = clk_seen;
                     ack_cnt_in = ack_cnt_next;
                     if (ack_new) begin
                        ack_seen_in[req_ch.sender] = 1'b1;
                     end
                     if (mode_ff == MODE_WAIT && ack_cnt_next >= need) begin
                        mode_in = MODE_SECTION;
                     end
                     state_in = ST_EMPTY;
                  end
                  ACT_REQUEST: begin
                     if (mode_ff == MODE_REST) begin
                        ack_cnt_in   = '0;
                        ack_seen_in  = '0;
                        deferred_in  = '0;
                        stamp_vld_in = '0;
                        held_in      = req_ch.resource;
                        clk_in       = clk_inc;
                        mode_in      = (need == '0) ? MODE_SECTION : MODE_WAIT;
                        mask_in      = peer_mask;
                        kind_in      = KIND_REQ;
                        state_in     = (peer_mask == '0) ? ST_EMPTY : ST_SCAN;
                     end else begin
                        state_in = ST_EMPTY;
                     end
                  end
                  ACT_RELEASE: begin
                     if (mode_ff == MODE_SECTION) begin
                        mask_in     = deferred_ff;
                        kind_in     = KIND_ACK;
                        res_in      = held_ff;
                        deferred_in = '0;
                        held_in     = '0;
                        mode_in     = MODE_REST;
                        state_in    = (deferred_ff == '0) ? ST_EMPTY : ST_SCAN;
                     end else begin
                        state_in = ST_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_JUDGE: begin
            if (out_free) begin
               push.valid           = 1'b1;
               push.item.node_state = mode_ff;
               push.item.last       = 1'b1;
               if (answer) begin
                  clk_in                   = clk_inc;
                  push.item.send_valid     = 1'b1;
                  push.item.send_kind      = KIND_ACK;
                  push.item.dest_node      = snd_ff;
                  push.item.send_resource  = res_ff;
                  push.item.send_timestamp = clk_inc;
               end else begin
                  deferred_in[snd_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         ST_EMPTY: begin
            if (out_free) begin
               push.valid           = 1'b1;
               push.item.node_state = mode_ff;
               push.item.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (out_free) begin
               clk_in                   = clk_inc;
               push.valid               = 1'b1;
               push.item.send_valid     = 1'b1;
               push.item.send_kind      = kind_ff;
               push.item.dest_node      = low_idx;
               push.item.send_resource  = res_ff;
               push.item.send_timestamp = clk_inc;
               push.item.node_state     = mode_ff;
               push.item.last           = scan_last;
               mask_in                  = mask_ff & ~low_bit;
               // a request stamps each peer as it goes out
               if (kind_ff == KIND_REQ) begin
                  ram_cmd.wr_en          = 1'b1;
                  ram_cmd.addr           = low_idx;
                  ram_cmd.wdata          = clk_inc;
                  stamp_vld_in[low_idx]  = 1'b1;
               end
               if (scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and protocol state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clk_ff        <= '0;
         mode_ff       <= MODE_REST;
         held_ff       <= '0;
         ack_cnt_ff    <= '0;
         ack_seen_ff   <= '0;
         deferred_ff   <= '0;
         stamp_vld_ff  <= '0;
         mask_ff       <= '0;
         my_node_ff    <= '0;
         node_count_ff <= CNT_W'(2);
      end else begin
         state_ff      <= state_in;
         clk_ff        <= clk_in;
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         ack_cnt_ff    <= ack_cnt_in;
         ack_seen_ff   <= ack_seen_in;
         deferred_ff   <= deferred_in;
         stamp_vld_ff  <= stamp_vld_in;
         mask_ff       <= mask_in;
         my_node_ff    <= my_node_in;
         node_count_ff <= node_count_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      res_ff  <= res_in;
      ts_ff   <= ts_in;
      snd_ff  <= snd_in;
   end

endmodule

@@ rtl/ricart_agrawala_mutex_node.sv @@
// Every action gives its first result through the sequencer (which also covers
// the stamp read for a received REQ) and then the output register; a request or
// release then sends one message a cycle while the output register is free, as
// the walk takes one peer at a time over the single-port stamp memory; the node
// takes no new action until the walk is done.
// Synchronous active-high reset clears clock, mode, marks and registers
// (my_node 0, node_count 2); the stamp memory needs no clear.
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node
// One Ricart-Agrawala mutual exclusion node with a wrapping Lamport clock;
// request stamps live in a synchronous memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ricart_agrawala_mutex_node
   import ra_mutex_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   ra_mutex_req_if.sink   req_ch,
   ra_mutex_rsp_if.source rsp_ch,
   ra_mutex_csr_if.sink   csr_ch
);

   ram_cmd_type     ram_cmd;
   logic [TS_W-1:0] ram_rdata;
   rsp_push_type    push;
   logic            out_free;

   // protocol sequencer
   ra_mutex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata),
      .out_free  (out_free),
      .push      (push)
   );

   // request stamps
   ra_mutex_stamp_ram u_stamp_ram (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   // result register
   ra_mutex_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

endmodule

@@ verif/ricart_agrawala_mutex_node_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node_tb
// Self-checking bench for one mutual exclusion node. A behavioral copy of the
// node (Lamport clock, mode, ACK and deferral marks, request stamps) predicts
// every outgoing message at input transfer time; a monitor compares each
// result transfer field by field. Directed cases cover clock wrap, priority
// ties, non-peer traffic and single-node operation; random protocol traffic
// then runs under several node ids and node counts with random stalls.
// ----------------------------------------------------------------------------

module ricart_agrawala_mutex_node_tb;
   import ra_mutex_pkg::*;

   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ra_mutex_req_if req_bus ();
   ra_mutex_rsp_if rsp_bus ();
   ra_mutex_csr_if csr_bus ();

   ricart_agrawala_mutex_node u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the node state
   logic [NODE_W-1:0] cfg_node  = '0;
   logic [CNT_W-1:0]  cfg_count = 5'd2;
   logic [TS_W-1:0]   shadow_clock = '0;
   logic [1:0]        node_mode = MODE_REST;
   logic [RES_W-1:0]  held_res = '0;
   logic [CNT_W-1:0]  ack_total = '0;
   logic              ack_mark   [MAX_NODES];
   logic              defer_mark [MAX_NODES];
   logic [TS_W-1:0]   req_stamp  [MAX_NODES];

   rsp_item_type pending_msgs[$];
   int  mismatches   = 0;
   int  rsp_hold_len = 0;
   bit  idle_en      = 1'b1;
   bit  stall_en     = 1'b1;
   int  quiet_cycles = 0;

   initial begin
      for (int i = 0; i < MAX_NODES; i++) begin
         ack_mark[i]   = 1'b0;
         defer_mark[i] = 1'b0;
         req_stamp[i]  = '0;
      end
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic int active_nodes();
      if (cfg_count == 0) return 1;
      if (cfg_count > MAX_NODES) return MAX_NODES;
      return cfg_count;
   endfunction

   function automatic bit is_peer_id(input logic [NODE_W-1:0] id);
      int n;
      int me;
      int idx;
      n   = active_nodes();
      me  = cfg_node;
      idx = id;
      if (idx == me) return 1'b0;
      if (me < n) return idx < n;
      return idx < n - 1;
   endfunction

   // lamport update: max(clock, seen) + 1, wrapping
   function automatic void bump_clock(input logic [TS_W-1:0] seen);
      shadow_clock = ((shadow_clock > seen) ? shadow_clock : seen) + 1'b1;
   endfunction

   function automatic rsp_item_type make_msg(input logic kind, input logic [NODE_W-1:0] dest,
                                             input logic [RES_W-1:0] res,
                                             input logic [TS_W-1:0] stamp);
      rsp_item_type m;
      m = '0;
      m.send_valid     = 1'b1;
      m.send_kind      = kind;
      m.dest_node      = dest;
      m.send_resource  = res;
      m.send_timestamp = stamp;
      return m;
   endfunction

   task automatic predict_node_step(input logic [1:0] act, input logic [TS_W-1:0] ts,
                                    input logic [NODE_W-1:0] snd, input logic [RES_W-1:0] res);
      rsp_item_type msgs[$];
      rsp_item_type m;
      logic answer;
      int need;
      need = active_nodes() - 1;
      case (act)
         ACT_RECV_REQ: begin
            bump_clock(ts);
            if (!is_peer_id(snd) || node_mode == MODE_REST)
               answer = 1'b1;
            else if (node_mode == MODE_WAIT) begin
               if (held_res != res)
                  answer = 1'b1;
               else
                  answer = (ts < req_stamp[snd]) ||
                           (ts == req_stamp[snd] && snd < cfg_node);
            end else
               answer = (held_res != res);
            if (answer) begin
               bump_clock('0);
               msgs.push_back(make_msg(KIND_ACK, snd, res, shadow_clock));
            end else
               defer_mark[snd] = 1'b1;
         end
         ACT_RECV_ACK: begin
            bump_clock(ts);
            if (is_peer_id(snd) && !ack_mark[snd]) begin
               ack_mark[snd] = 1'b1;
               ack_total     = ack_total + 1'b1;
            end
            if (node_mode == MODE_WAIT && ack_total >= need) node_mode = MODE_SECTION;
         end
         ACT_REQUEST: begin
            if (node_mode == MODE_REST) begin
               ack_total = '0;
               for (int i = 0; i < MAX_NODES; i++) begin
                  ack_mark[i]   = 1'b0;
                  defer_mark[i] = 1'b0;
                  req_stamp[i]  = '0;
               end
               held_res  = res;
               node_mode = MODE_WAIT;
               bump_clock('0);
               for (int i = 0; i < MAX_NODES; i++) begin
                  if (is_peer_id(i)) begin
                     bump_clock('0);
                     req_stamp[i] = shadow_clock;
                     msgs.push_back(make_msg(KIND_REQ, i, res, shadow_clock));
                  end
               end
               if (need == 0) node_mode = MODE_SECTION;
            end
         end
         default: begin
            if (node_mode == MODE_SECTION) begin
               for (int i = 0; i < MAX_NODES; i++) begin
                  if (defer_mark[i]) begin
                     bump_clock('0);
                     msgs.push_back(make_msg(KIND_ACK, i, held_res, shadow_clock));
                     defer_mark[i] = 1'b0;
                  end
               end
               node_mode = MODE_REST;
               held_res  = '0;
            end
         end
      endcase
      // a step with nothing to send still reports the mode once
      if (msgs.size() == 0) msgs.push_back('0);
      for (int j = 0; j < msgs.size(); j++) begin
         m            = msgs[j];
         m.node_state = node_mode;
         m.last       = (j == msgs.size() - 1);
         pending_msgs.push_back(m);
      end
   endtask

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] expv,
                                       input logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, expv, actv);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type exp_msg;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_msgs.size() == 0) begin
            $error("result transfer with no expected message (dest %0d, ts 0x%0h)",
                   rsp_bus.dest_node, rsp_bus.send_timestamp);
            mismatches++;
         end else begin
            exp_msg = pending_msgs.pop_front();
            check_field("send_valid", exp_msg.send_valid, rsp_bus.send_valid);
            check_field("send_kind", exp_msg.send_kind, rsp_bus.send_kind);
            check_field("dest_node", exp_msg.dest_node, rsp_bus.dest_node);
            check_field("send_resource", exp_msg.send_resource, rsp_bus.send_resource);
            check_field("send_timestamp", exp_msg.send_timestamp, rsp_bus.send_timestamp);
            check_field("node_state", exp_msg.node_state, rsp_bus.node_state);
            check_field("last", exp_msg.last, rsp_bus.last);
         end
      end
   end

   // result ready: random stall bursts plus an occasional long hold-off
   initial begin : rsp_ready_driver
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end else if (stall_en && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // one input transfer; valid stays up so the next item can follow directly
   task automatic send_item(input logic [1:0] act, input logic [TS_W-1:0] ts,
                            input logic [NODE_W-1:0] snd, input logic [RES_W-1:0] res);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.msg_timestamp <= ts;
      req_bus.sender        <= snd;
      req_bus.resource      <= res;
      do @(posedge clock); while (!req_bus.ready);
      predict_node_step(act, ts, snd, res);
   endtask

   // stop offering and wait until every expected message has come out
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // finish any open request so the node sits at rest
   task automatic return_to_rest();
      if (node_mode == MODE_WAIT)
         for (int i = 0; i < MAX_NODES; i++)
            if (is_peer_id(i) && !ack_mark[i])
               send_item(ACT_RECV_ACK, shadow_clock, i, '0);
      if (node_mode == MODE_SECTION) send_item(ACT_RELEASE, '0, '0, '0);
   endtask

   task automatic write_config(input logic [NODE_W-1:0] node_id, input logic [CNT_W-1:0] count);
      return_to_rest();
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_MY_NODE;
      csr_bus.wdata <= CSR_DAT_W'(node_id);
      do @(posedge clock); while (!csr_bus.ready);
      cfg_node = node_id;
      csr_bus.index <= CSR_NODE_COUNT;
      csr_bus.wdata <= count;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_count = count;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [NODE_W-1:0] pick_peer();
      logic [NODE_W-1:0] id;
      id = $urandom_range(0, MAX_NODES - 1);
      if (active_nodes() > 1)
         while (!is_peer_id(id)) id = $urandom_range(0, MAX_NODES - 1);
      return id;
   endfunction

   // mostly near the local clock, sometimes anywhere, sometimes at the wrap
   function automatic logic [TS_W-1:0] pick_stamp();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return shadow_clock - $urandom_range(0, 3);
      if (r < 7) return shadow_clock + $urandom_range(0, 3);
      if (r < 9) return $urandom;
      return 32'hFFFF_FFFF - $urandom_range(0, 3);
   endfunction

   // a small pool so requests collide, with the full range now and then
   function automatic logic [RES_W-1:0] pick_resource();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, 2);
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset defaults (node 0 of 2), clock wrap, traffic at rest
   task automatic test_rest_traffic();
      send_item(ACT_RECV_REQ, 32'hFFFF_FFFF, 4'd1, 8'd0);
      send_item(ACT_RECV_ACK, 32'h0000_0000, 4'd1, 8'd0);
      send_item(ACT_RELEASE, '0, '0, '0);
      drain();
   endtask

   // own request against incoming requests: ties, lower, higher, other resource
   task automatic test_request_priority();
      send_item(ACT_REQUEST, '0, '0, 8'hFF);
      send_item(ACT_REQUEST, '0, '0, 8'h11);
      send_item(ACT_RECV_REQ, req_stamp[1], 4'd1, 8'hFF);
      send_item(ACT_RECV_REQ, req_stamp[1] - 1'b1, 4'd1, 8'hFF);
      send_item(ACT_RECV_REQ, req_stamp[1] + 1'b1, 4'd1, 8'hFF);
      send_item(ACT_RECV_REQ, shadow_clock, 4'd1, 8'h00);
      send_item(ACT_RECV_REQ, shadow_clock, 4'd15, 8'hFF);
      send_item(ACT_RECV_ACK, shadow_clock, 4'd15, 8'h00);
      send_item(ACT_RECV_ACK, 32'h0, 4'd1, 8'h00);
      send_item(ACT_RECV_ACK, 32'h0, 4'd1, 8'h00);
      send_item(ACT_RECV_REQ, shadow_clock, 4'd1, 8'hFF);
      send_item(ACT_RECV_REQ, shadow_clock, 4'd1, 8'h07);
      send_item(ACT_RELEASE, '0, '0, '0);
      send_item(ACT_RELEASE, '0, '0, '0);
      drain();
   endtask

   // one node alone enters at once; a count of zero acts as one
   task automatic test_single_node();
      write_config(4'd4, 5'd1);
      send_item(ACT_REQUEST, '0, '0, 8'h5A);
      send_item(ACT_RELEASE, '0, '0, '0);
      write_config(4'd0, 5'd0);
      send_item(ACT_REQUEST, '0, '0, 8'hA5);
      send_item(ACT_RELEASE, '0, '0, '0);
      drain();
   endtask

   // own id outside the node range: peers are the lowest ids
   task automatic test_high_node_id();
      write_config(4'd15, 5'd4);
      send_item(ACT_REQUEST, '0, '0, 8'd3);
      send_item(ACT_RECV_REQ, req_stamp[2], 4'd2, 8'd3);
      send_item(ACT_RECV_REQ, req_stamp[1] + 5, 4'd1, 8'd3);
      send_item(ACT_RECV_ACK, shadow_clock, 4'd0, 8'd0);
      send_item(ACT_RECV_ACK, shadow_clock, 4'd1, 8'd0);
      send_item(ACT_RECV_ACK, shadow_clock, 4'd2, 8'd0);
      send_item(ACT_RELEASE, '0, '0, '0);
      drain();
   endtask

   // full fan-out while results are held off, so the node stalls its input
   task automatic test_backpressure();
      write_config(4'd0, 5'd16);
      rsp_hold_len = LONG_HOLD;
      @(posedge clock);
      while (rsp_bus.ready) @(posedge clock);
      send_item(ACT_REQUEST, '0, '0, pick_resource());
      for (int k = 0; k < 12; k++)
         send_item(ACT_RECV_REQ, pick_stamp(), pick_peer(), held_res);
      return_to_rest();
      drain();
   endtask

   // protocol-shaped random traffic with some noise
   task automatic test_random_traffic(input int n_items, input logic [NODE_W-1:0] node_id,
                                      input logic [CNT_W-1:0] count);
      logic [1:0]        act;
      logic [NODE_W-1:0] snd;
      logic [RES_W-1:0]  res;
      int                r;
      write_config(node_id, count);
      for (int k = 0; k < n_items; k++) begin
         r   = $urandom_range(0, 99);
         snd = pick_peer();
         res = ($urandom_range(0, 9) < 6) ? held_res : pick_resource();
         if (r < 10) begin
            act = $urandom_range(ACT_RECV_REQ, ACT_RELEASE);
            send_item(act, $urandom, $urandom_range(0, MAX_NODES - 1), $urandom_range(0, 255));
         end else begin
            case (node_mode)
               MODE_REST: begin
                  if (r < 60) send_item(ACT_REQUEST, '0, '0, pick_resource());
                  else send_item(ACT_RECV_REQ, pick_stamp(), snd, pick_resource());
               end
               MODE_WAIT: begin
                  if (r < 65) send_item(ACT_RECV_ACK, pick_stamp(), snd, '0);
                  else if (r < 85)
                     send_item(ACT_RECV_REQ, req_stamp[snd] + $urandom_range(0, 2) - 1,
                               snd, res);
                  else send_item(ACT_RECV_REQ, pick_stamp(), snd, res);
               end
               default: begin
                  if (r < 40) send_item(ACT_RELEASE, '0, '0, '0);
                  else send_item(ACT_RECV_REQ, pick_stamp(), snd, res);
               end
            endcase
         end
      end
      drain();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_RECV_REQ;
      req_bus.msg_timestamp <= '0;
      req_bus.sender        <= '0;
      req_bus.resource      <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_MY_NODE;
      csr_bus.wdata         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_rest_traffic();
      test_request_priority();
      test_single_node();
      test_high_node_id();
      test_backpressure();
      test_random_traffic(10, 4'd3, 5'd5);
      test_random_traffic(10, 4'd15, 5'd16);
      test_random_traffic(10, 4'd12, 5'd4);
      test_random_traffic(10, 4'd7, 5'd31);
      // last stretch runs without idling on either side
      idle_en  = 1'b0;
      stall_en = 1'b0;
      test_random_traffic(10, $urandom_range(0, 15), $urandom_range(2, 31));

      drain();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
